// ----- hdl/lkvc_pkg.sv -----
package lkvc_pkg;

    localparam int ENTRIES_DEF    = 16;
    localparam int DATA_BITS_DEF  = 32;
    localparam int WORD_BITS      = 32;
    localparam int KEY_BITS       = 31;
    localparam int HITS_BITS      = 32;
    localparam int STAMP_BITS     = 40;
    localparam int CAP_BITS       = 5;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 32;

    localparam logic [CAP_BITS-1:0]       CAP_RESET      = CAP_BITS'(16);
    localparam logic                      FIXED_RESET    = 1'b1;
    localparam logic [HITS_BITS-1:0]      HITS_MAX       = '1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_CAPACITY   = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] REG_FIXED_MODE = CFG_INDEX_BITS'(1);

    typedef enum logic [1:0] {
        FUNC_PUT    = 2'd0,
        FUNC_GET    = 2'd1,
        FUNC_DELETE = 2'd2,
        FUNC_EXISTS = 2'd3
    } lkvc_func_t;

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_BAD_KEY = 2'd1,
        STATUS_FULL    = 2'd2
    } lkvc_status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DECIDE,
        ST_RESP
    } lkvc_state_t;

    // Write control for the entry store; each field of an entry has its own enable.
    typedef struct packed {
        logic en;
        logic set_valid;
        logic clr_valid;
        logic wr_key;
        logic wr_data;
        logic wr_hits;
        logic wr_stamp;
    } lkvc_wr_t;

    // Outcome flags of one pass of the scan unit.
    typedef struct packed {
        logic found;
        logic free_found;
        logic best_found;
    } lkvc_scan_flags_t;

endpackage

// ----- hdl/lkvc_req_if.sv -----
interface lkvc_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         func;
    logic signed [31:0] key;
    logic [31:0]        data_in;

    modport source (output valid, func, key, data_in, input ready);
    modport sink   (input valid, func, key, data_in, output ready);
endinterface

// ----- hdl/lkvc_rsp_if.sv -----
interface lkvc_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic        hit;
    logic [31:0] data_out;
    logic [31:0] hit_count_out;
    logic        evicted;
    logic [30:0] evicted_key;

    modport source (output valid, status, hit, data_out, hit_count_out, evicted, evicted_key,
                    input ready);
    modport sink   (input valid, status, hit, data_out, hit_count_out, evicted, evicted_key,
                    output ready);
endinterface

// ----- hdl/lkvc_cfg_if.sv -----
interface lkvc_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [31:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- hdl/lfu_key_value_cache_top.sv -----
// A result is offered once the scan unit has walked every slot of the entry store and the
// write-back is done; an item with a negative key is offered its result in the next cycle.
// The scan unit reads one slot of the entry store per cycle through its single read port;
// a new item is taken only once the result of the last one has been taken.
// Reset: rst_n is asynchronous and active low; it empties every slot, clears the entry
// count and the sequence counter, and sets capacity to 16 and fixed mode on.
module lfu_key_value_cache_top
    import lkvc_pkg::*;
#(
    parameter int ENTRIES   = ENTRIES_DEF,
    parameter int DATA_BITS = DATA_BITS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    lkvc_req_if.sink   req,
    lkvc_rsp_if.source rsp,
    lkvc_cfg_if.sink   cfg
);

    localparam int IW    = $clog2(ENTRIES);
    localparam int CNT_W = $clog2(ENTRIES + 1);
    // Width wide enough to compare the entry count with the capacity register.
    localparam int CMP_W = (CNT_W > CAP_BITS) ? CNT_W : CAP_BITS;

    // Configuration registers.
    logic [CAP_BITS-1:0]   cap_reg;
    logic                  fixed_reg;

    // Sequencer state and counters.
    lkvc_state_t           state_reg;
    lkvc_state_t           state_next;
    logic [IW-1:0]         scan_cnt_reg;
    logic [IW-1:0]         scan_cnt_next;
    logic [CNT_W-1:0]      count_reg;
    logic [STAMP_BITS-1:0] seq_reg;

    // The item being worked on.
    lkvc_func_t            func_reg;
    logic [KEY_BITS-1:0]   key_reg;
    logic [DATA_BITS-1:0]  data_reg;
    logic [STAMP_BITS-1:0] stamp_reg;

    // Result register, held until the output transfer.
    logic [1:0]            status_reg;
    logic                  hit_reg;
    logic [WORD_BITS-1:0]  dout_reg;
    logic [HITS_BITS-1:0]  hcount_reg;
    logic                  evicted_reg;
    logic [KEY_BITS-1:0]   evkey_reg;

    logic                  req_xfer;
    logic                  rsp_xfer;
    logic                  bad_key;
    logic                  scan_start;
    logic                  rd_en;

    // Store read side and scan results.
    logic                  rd_valid;
    logic [KEY_BITS-1:0]   rd_key;
    logic [DATA_BITS-1:0]  rd_data;
    logic [HITS_BITS-1:0]  rd_hits;
    logic [STAMP_BITS-1:0] rd_stamp;
    lkvc_scan_flags_t      flags;
    logic [IW-1:0]         match_idx;
    logic [DATA_BITS-1:0]  match_data;
    logic [HITS_BITS-1:0]  match_hits;
    logic [IW-1:0]         free_idx;
    logic [IW-1:0]         best_idx;
    logic [KEY_BITS-1:0]   best_key;

    // Decision made once the scan is complete.
    logic [CMP_W-1:0]      cap_ext;
    logic [CMP_W-1:0]      cap_eff;
    logic                  full;
    logic [HITS_BITS-1:0]  hits_inc;
    lkvc_wr_t              dec_wr;
    lkvc_wr_t              st_wr;
    logic [IW-1:0]         dec_addr;
    logic [HITS_BITS-1:0]  dec_hits;
    lkvc_status_t          dec_status;
    logic                  dec_evict;
    logic                  dec_cnt_inc;
    logic                  dec_cnt_dec;

    assign req_xfer = req.valid && req.ready;
    assign rsp_xfer = rsp.valid && rsp.ready;
    // Bit 31 of the key is its sign: a negative key is rejected without a scan.
    assign bad_key  = req.key[WORD_BITS-1];

    // Configuration writes are to be made only while the block is idle; the block
    // itself does not enforce this. They are always taken.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg   <= CAP_RESET;
            fixed_reg <= FIXED_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                REG_CAPACITY:   cap_reg   <= cfg.data[CAP_BITS-1:0];
                REG_FIXED_MODE: fixed_reg <= cfg.data[0];
                default:        ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sequencer. An accepted item with a valid key walks the store once,
    // one slot per cycle, passes through the drain state while the last
    // slot is judged, then writes back and offers its result.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            scan_cnt_reg <= '0;
            count_reg    <= '0;
            seq_reg      <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            scan_cnt_reg <= scan_cnt_next;
            if (req_xfer)
            begin
                seq_reg <= seq_reg + STAMP_BITS'(1);
            end
            if (state_reg == ST_DECIDE)
            begin
                if (dec_cnt_inc)
                begin
                    count_reg <= count_reg + CNT_W'(1);
                end
                else if (dec_cnt_dec)
                begin
                    count_reg <= count_reg - CNT_W'(1);
                end
            end
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        scan_cnt_next = scan_cnt_reg;
        req.ready     = 1'b0;
        rsp.valid     = 1'b0;
        scan_start    = 1'b0;
        rd_en         = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                req.ready     = 1'b1;
                scan_cnt_next = '0;
                if (req.valid)
                begin
                    if (bad_key)
                    begin
                        state_next = ST_RESP;
                    end
                    else
                    begin
                        scan_start = 1'b1;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                rd_en         = 1'b1;
                scan_cnt_next = scan_cnt_reg + IW'(1);
                if (scan_cnt_reg == IW'(ENTRIES - 1))
                begin
                    scan_cnt_next = '0;
                    state_next    = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                rsp.valid = 1'b1;
                if (rsp.ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Item and result registers.
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (req_xfer)
        begin
            func_reg  <= lkvc_func_t'(req.func);
            key_reg   <= req.key[KEY_BITS-1:0];
            data_reg  <= DATA_BITS'(req.data_in);
            stamp_reg <= seq_reg;
            if (bad_key)
            begin
                status_reg  <= STATUS_BAD_KEY;
                hit_reg     <= 1'b0;
                dout_reg    <= '0;
                hcount_reg  <= '0;
                evicted_reg <= 1'b0;
                evkey_reg   <= '0;
            end
        end
        if (state_reg == ST_DECIDE)
        begin
            status_reg  <= dec_status;
            hit_reg     <= flags.found;
            dout_reg    <= '0;
            hcount_reg  <= '0;
            evicted_reg <= dec_evict;
            evkey_reg   <= dec_evict ? best_key : '0;
            if ((func_reg == FUNC_GET) && flags.found)
            begin
                dout_reg   <= WORD_BITS'(match_data);
                hcount_reg <= hits_inc;
            end
        end
    end

    // ------------------------------------------------------------------
    // Write-back decision. A capacity of zero behaves as one and anything
    // above the number of slots behaves as the number of slots.
    // ------------------------------------------------------------------
    assign cap_ext  = CMP_W'(cap_reg);
    assign cap_eff  = (cap_ext == '0) ? CMP_W'(1) :
                      ((cap_ext > CMP_W'(ENTRIES)) ? CMP_W'(ENTRIES) : cap_ext);
    assign full     = CMP_W'(count_reg) >= cap_eff;
    // The hit count saturates rather than wrapping.
    assign hits_inc = (match_hits == HITS_MAX) ? match_hits : match_hits + HITS_BITS'(1);

    always_comb
    begin
        dec_wr      = '0;
        dec_addr    = match_idx;
        dec_hits    = hits_inc;
        dec_status  = STATUS_OK;
        dec_evict   = 1'b0;
        dec_cnt_inc = 1'b0;
        dec_cnt_dec = 1'b0;
        unique case (func_reg)
            FUNC_PUT:
            begin
                if (flags.found)
                begin
                    // Update of a present key: new data and stamp, hits kept.
                    dec_wr.en       = 1'b1;
                    dec_wr.wr_data  = 1'b1;
                    dec_wr.wr_stamp = 1'b1;
                end
                else if (full)
                begin
                    if (fixed_reg && flags.best_found)
                    begin
                        // Eviction reuses the victim's slot, so the count stays.
                        dec_evict       = 1'b1;
                        dec_addr        = best_idx;
                        dec_hits        = '0;
                        dec_wr.en       = 1'b1;
                        dec_wr.wr_key   = 1'b1;
                        dec_wr.wr_data  = 1'b1;
                        dec_wr.wr_hits  = 1'b1;
                        dec_wr.wr_stamp = 1'b1;
                    end
                    else
                    begin
                        dec_status = STATUS_FULL;
                    end
                end
                else if (flags.free_found)
                begin
                    dec_addr         = free_idx;
                    dec_hits         = '0;
                    dec_cnt_inc      = 1'b1;
                    dec_wr.en        = 1'b1;
                    dec_wr.set_valid = 1'b1;
                    dec_wr.wr_key    = 1'b1;
                    dec_wr.wr_data   = 1'b1;
                    dec_wr.wr_hits   = 1'b1;
                    dec_wr.wr_stamp  = 1'b1;
                end
                else
                begin
                    dec_status = STATUS_FULL;
                end
            end
            FUNC_GET:
            begin
                if (flags.found)
                begin
                    dec_wr.en       = 1'b1;
                    dec_wr.wr_hits  = 1'b1;
                    dec_wr.wr_stamp = 1'b1;
                end
            end
            FUNC_DELETE:
            begin
                if (flags.found)
                begin
                    dec_wr.en        = 1'b1;
                    dec_wr.clr_valid = 1'b1;
                    dec_cnt_dec      = (count_reg != '0);
                end
            end
            FUNC_EXISTS:
            begin
                // A pure lookup: only the hit flag is reported.
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        st_wr    = dec_wr;
        st_wr.en = dec_wr.en && (state_reg == ST_DECIDE);
    end

    lkvc_store #(
        .ENTRIES   (ENTRIES),
        .DATA_BITS (DATA_BITS)
    ) u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (rd_en),
        .rd_addr  (scan_cnt_reg),
        .rd_valid (rd_valid),
        .rd_key   (rd_key),
        .rd_data  (rd_data),
        .rd_hits  (rd_hits),
        .rd_stamp (rd_stamp),
        .wr       (st_wr),
        .wr_addr  (dec_addr),
        .wr_key   (key_reg),
        .wr_data  (data_reg),
        .wr_hits  (dec_hits),
        .wr_stamp (stamp_reg)
    );

    lkvc_scan #(
        .ENTRIES   (ENTRIES),
        .DATA_BITS (DATA_BITS)
    ) u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (scan_start),
        .issue      (rd_en),
        .issue_idx  (scan_cnt_reg),
        .key        (key_reg),
        .rd_valid   (rd_valid),
        .rd_key     (rd_key),
        .rd_data    (rd_data),
        .rd_hits    (rd_hits),
        .rd_stamp   (rd_stamp),
        .flags      (flags),
        .match_idx  (match_idx),
        .match_data (match_data),
        .match_hits (match_hits),
        .free_idx   (free_idx),
        .best_idx   (best_idx),
        .best_key   (best_key)
    );

    // ------------------------------------------------------------------
    // Output port.
    // ------------------------------------------------------------------
    assign rsp.status        = status_reg;
    assign rsp.hit           = hit_reg;
    assign rsp.data_out      = dout_reg;
    assign rsp.hit_count_out = hcount_reg;
    assign rsp.evicted       = evicted_reg;
    assign rsp.evicted_key   = evkey_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(ENTRIES))
        else $error("entry count exceeds the number of slots");

    a_store_write_decide: assert property (@(posedge clk) disable iff (!rst_n)
        st_wr.en |-> (state_reg == ST_DECIDE))
        else $error("entry store written outside the write-back cycle");

    a_evict_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DECIDE && dec_evict) |=> $stable(count_reg))
        else $error("eviction changed the entry count");

    a_bad_key_fast: assert property (@(posedge clk) disable iff (!rst_n)
        (req_xfer && bad_key) |=> (state_reg == ST_RESP && status_reg == STATUS_BAD_KEY))
        else $error("negative key not answered at once");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        !(req.ready && rsp.valid))
        else $error("new item taken while a result is pending");

endmodule

// ----- hdl/lkvc_store.sv -----
module lkvc_store
    import lkvc_pkg::*;
#(
    parameter int ENTRIES   = ENTRIES_DEF,
    parameter int DATA_BITS = DATA_BITS_DEF,
    localparam int IW       = $clog2(ENTRIES)
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  rd_en,
    input  logic [IW-1:0]         rd_addr,
    output logic                  rd_valid,
    output logic [KEY_BITS-1:0]   rd_key,
    output logic [DATA_BITS-1:0]  rd_data,
    output logic [HITS_BITS-1:0]  rd_hits,
    output logic [STAMP_BITS-1:0] rd_stamp,
    input  lkvc_wr_t              wr,
    input  logic [IW-1:0]         wr_addr,
    input  logic [KEY_BITS-1:0]   wr_key,
    input  logic [DATA_BITS-1:0]  wr_data,
    input  logic [HITS_BITS-1:0]  wr_hits,
    input  logic [STAMP_BITS-1:0] wr_stamp
);

    logic [KEY_BITS-1:0]   key_mem   [ENTRIES];
    logic [DATA_BITS-1:0]  data_mem  [ENTRIES];
    logic [HITS_BITS-1:0]  hits_mem  [ENTRIES];
    logic [STAMP_BITS-1:0] stamp_mem [ENTRIES];
    logic [ENTRIES-1:0]    valid_reg;
    logic                  rd_valid_reg;
    logic [KEY_BITS-1:0]   rd_key_reg;
    logic [DATA_BITS-1:0]  rd_data_reg;
    logic [HITS_BITS-1:0]  rd_hits_reg;
    logic [STAMP_BITS-1:0] rd_stamp_reg;

    // Valid bits live in flip-flops so that reset empties the cache at once.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr.en && wr.set_valid)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            else if (wr.en && wr.clr_valid)
            begin
                valid_reg[wr_addr] <= 1'b0;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.en && wr.wr_key)
        begin
            key_mem[wr_addr] <= wr_key;
        end
        if (wr.en && wr.wr_data)
        begin
            data_mem[wr_addr] <= wr_data;
        end
        if (wr.en && wr.wr_hits)
        begin
            hits_mem[wr_addr] <= wr_hits;
        end
        if (wr.en && wr.wr_stamp)
        begin
            stamp_mem[wr_addr] <= wr_stamp;
        end
        if (rd_en)
        begin
            rd_key_reg   <= key_mem[rd_addr];
            rd_data_reg  <= data_mem[rd_addr];
            rd_hits_reg  <= hits_mem[rd_addr];
            rd_stamp_reg <= stamp_mem[rd_addr];
        end
    end

    assign rd_valid = rd_valid_reg;
    assign rd_key   = rd_key_reg;
    assign rd_data  = rd_data_reg;
    assign rd_hits  = rd_hits_reg;
    assign rd_stamp = rd_stamp_reg;

endmodule

// ----- hdl/lkvc_scan.sv -----
module lkvc_scan
    import lkvc_pkg::*;
#(
    parameter int ENTRIES   = ENTRIES_DEF,
    parameter int DATA_BITS = DATA_BITS_DEF,
    localparam int IW       = $clog2(ENTRIES)
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic                  issue,
    input  logic [IW-1:0]         issue_idx,
    input  logic [KEY_BITS-1:0]   key,
    input  logic                  rd_valid,
    input  logic [KEY_BITS-1:0]   rd_key,
    input  logic [DATA_BITS-1:0]  rd_data,
    input  logic [HITS_BITS-1:0]  rd_hits,
    input  logic [STAMP_BITS-1:0] rd_stamp,
    output lkvc_scan_flags_t      flags,
    output logic [IW-1:0]         match_idx,
    output logic [DATA_BITS-1:0]  match_data,
    output logic [HITS_BITS-1:0]  match_hits,
    output logic [IW-1:0]         free_idx,
    output logic [IW-1:0]         best_idx,
    output logic [KEY_BITS-1:0]   best_key
);

    logic                  smp_en_reg;
    logic [IW-1:0]         smp_idx_reg;
    lkvc_scan_flags_t      flags_reg;
    logic [IW-1:0]         match_idx_reg;
    logic [DATA_BITS-1:0]  match_data_reg;
    logic [HITS_BITS-1:0]  match_hits_reg;
    logic [IW-1:0]         free_idx_reg;
    logic [IW-1:0]         best_idx_reg;
    logic [KEY_BITS-1:0]   best_key_reg;
    logic [HITS_BITS-1:0]  best_hits_reg;
    logic [STAMP_BITS-1:0] best_stamp_reg;
    logic                  is_match;
    logic                  is_free;
    logic                  is_better;

    // One slot is judged per cycle; strict comparisons keep the lowest index on ties.
    assign is_match  = smp_en_reg && rd_valid && (rd_key == key);
    assign is_free   = smp_en_reg && !rd_valid && !flags_reg.free_found;
    assign is_better = smp_en_reg && rd_valid &&
                       (!flags_reg.best_found || (rd_hits < best_hits_reg) ||
                        ((rd_hits == best_hits_reg) && (rd_stamp < best_stamp_reg)));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            smp_en_reg <= 1'b0;
            flags_reg  <= '0;
        end
        else
        begin
            smp_en_reg <= issue;
            if (start)
            begin
                flags_reg <= '0;
            end
            else
            begin
                if (is_match)
                begin
                    flags_reg.found <= 1'b1;
                end
                if (is_free)
                begin
                    flags_reg.free_found <= 1'b1;
                end
                if (is_better)
                begin
                    flags_reg.best_found <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        smp_idx_reg <= issue_idx;
        if (is_match)
        begin
            match_idx_reg  <= smp_idx_reg;
            match_data_reg <= rd_data;
            match_hits_reg <= rd_hits;
        end
        if (is_free)
        begin
            free_idx_reg <= smp_idx_reg;
        end
        if (is_better)
        begin
            best_idx_reg   <= smp_idx_reg;
            best_key_reg   <= rd_key;
            best_hits_reg  <= rd_hits;
            best_stamp_reg <= rd_stamp;
        end
    end

    assign flags      = flags_reg;
    assign match_idx  = match_idx_reg;
    assign match_data = match_data_reg;
    assign match_hits = match_hits_reg;
    assign free_idx   = free_idx_reg;
    assign best_idx   = best_idx_reg;
    assign best_key   = best_key_reg;

endmodule
